### hdl/hmtq_pkg.sv
// Shared types, widths and codes for the min-heap timer queue.
package hmtq_pkg;

   localparam int REQ_W  = 2;
   localparam int ID_W   = 8;
   localparam int TIME_W = 32;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 6;   // heap count, depth up to 63
   localparam int SLOT_W = 5;   // slot within one heap level (at most 32 slots)
   localparam int POS_W  = 7;   // heap position of a child, may run past the depth
   localparam int LVLN_W = 3;   // level number as returned by level_of

   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

   localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_FIRED    = 2'd2;
   localparam logic [STAT_W-1:0] ST_DONE     = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [ID_W-1:0]   ident;
   } entry_type;

   // Sift token handed between neighbor cells.
   typedef struct packed {
      logic              valid;
      logic              here;   // place item at slot of the receiving level
      logic [SLOT_W-1:0] slot;
      entry_type         item;
   } token_type;

   // Entry write from a neighbor cell.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      entry_type         item;
   } write_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } fetch_type;

   // Level of a heap position, given as position plus one.
   function automatic logic [LVLN_W-1:0] level_of(input logic [CNT_W-1:0] pos_p1);
      logic [LVLN_W-1:0] lvl;
      lvl = '0;
      for (int k = 0; k < CNT_W; k++) begin
         if (pos_p1[k]) begin
            lvl = LVLN_W'(k);
         end
      end
      return lvl;
   endfunction

endpackage

### hdl/hmtq_if.sv
// Valid/ready channel interfaces for requests and responses.
interface hmtq_req_if;
   logic                         valid;
   logic                         ready;
   logic [hmtq_pkg::REQ_W-1:0]   req_type;
   logic [hmtq_pkg::ID_W-1:0]    timer_id;
   logic [hmtq_pkg::TIME_W-1:0]  time_value;

   modport source (output valid, req_type, timer_id, time_value, input ready);
   modport sink   (input valid, req_type, timer_id, time_value, output ready);
endinterface

interface hmtq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hmtq_pkg::ID_W-1:0]    fired_id;
   logic [hmtq_pkg::STAT_W-1:0]  status;
   logic                         last;

   modport source (output valid, fired_id, status, last, input ready);
   modport sink   (input valid, fired_id, status, last, output ready);
endinterface

### hdl/hmtq_cell.sv
// One heap level: slot storage plus the compare step of sift-up and sift-down.
module hmtq_cell #(
   parameter int LEVEL = 0,
   parameter bit LAST  = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hmtq_pkg::CNT_W-1:0]    count,
   input  hmtq_pkg::token_type           dn_tok_in,
   input  hmtq_pkg::token_type           up_tok_in,
   input  hmtq_pkg::write_type           wr_in,
   input  hmtq_pkg::fetch_type           fetch_in,
   output hmtq_pkg::token_type           dn_tok_out,
   output hmtq_pkg::token_type           up_tok_out,
   output hmtq_pkg::write_type           wr_up_out,
   output hmtq_pkg::write_type           wr_dn_out,
   output hmtq_pkg::entry_type           rd_entry,
   output logic                          done
);

   localparam int ROW_BITS = (LEVEL < 2) ? 1 : LEVEL - 1;
   localparam int ROWS     = 1 << ROW_BITS;
   localparam logic [hmtq_pkg::POS_W-1:0] BASE = hmtq_pkg::POS_W'((1 << LEVEL) - 1);

   typedef enum logic [3:0] {
      OP_NONE  = 4'b0001,
      OP_DOWN  = 4'b0010,
      OP_UP    = 4'b0100,
      OP_FETCH = 4'b1000
   } cell_op_type;

   // Slot 2r sits in the even bank, slot 2r+1 in the odd bank, both at row r.
   hmtq_pkg::entry_type mem_even [ROWS];
   hmtq_pkg::entry_type mem_odd  [ROWS];
   hmtq_pkg::entry_type rd_even_ff, rd_odd_ff;
   logic [ROW_BITS-1:0] rd_row;

   cell_op_type                   op_ff, op_in;
   logic [hmtq_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   hmtq_pkg::entry_type           item_ff, item_in;
   logic                          half_ff, half_in;

   hmtq_pkg::token_type dn_tok_ff, dn_tok_in_nx;
   hmtq_pkg::token_type up_tok_ff, up_tok_in_nx;
   hmtq_pkg::write_type wr_up_ff, wr_up_in;
   hmtq_pkg::write_type wr_dn_ff, wr_dn_in;
   logic                done_ff, done_in;

   logic [hmtq_pkg::SLOT_W-1:0] par_slot;
   logic                        here_wr;
   logic                        own_wr;
   logic [hmtq_pkg::SLOT_W-1:0] own_slot;
   logic                        mem_we;
   logic [hmtq_pkg::SLOT_W-1:0] mem_slot;
   hmtq_pkg::entry_type         mem_data;

   hmtq_pkg::entry_type         left, right, parent, child;
   logic [hmtq_pkg::POS_W-1:0]  left_pos, right_pos;
   logic                        left_ok, right_ok, take_right;
   logic [hmtq_pkg::SLOT_W-1:0] child_slot;

   assign par_slot = up_tok_in.slot >> 1;

   // Arrival: latch the token and start the registered read, or write a token marked here straight into its slot.
   always_comb begin
      op_in   = OP_NONE;
      slot_in = slot_ff;
      item_in = item_ff;
      half_in = half_ff;
      rd_row  = '0;
      here_wr = 1'b0;
      if (dn_tok_in.valid) begin
         op_in   = OP_DOWN;
         slot_in = dn_tok_in.slot;
         item_in = dn_tok_in.item;
         rd_row  = dn_tok_in.slot[ROW_BITS-1:0];
      end else if (up_tok_in.valid && up_tok_in.here) begin
         here_wr = 1'b1;
      end else if (up_tok_in.valid) begin
         op_in   = OP_UP;
         slot_in = up_tok_in.slot;
         item_in = up_tok_in.item;
         half_in = par_slot[0];
         rd_row  = par_slot[ROW_BITS:1];
      end else if (fetch_in.valid) begin
         op_in   = OP_FETCH;
         half_in = fetch_in.slot[0];
         rd_row  = fetch_in.slot[ROW_BITS:1];
      end
   end

   assign left       = rd_even_ff;
   assign right      = rd_odd_ff;
   assign parent     = half_ff ? rd_odd_ff : rd_even_ff;
   assign left_pos   = BASE + hmtq_pkg::POS_W'({slot_ff, 1'b0});
   assign right_pos  = left_pos + hmtq_pkg::POS_W'(1);
   assign left_ok    = left_pos < hmtq_pkg::POS_W'(count);
   assign right_ok   = right_pos < hmtq_pkg::POS_W'(count);
   assign take_right = right_ok && (right.expiry < left.expiry);
   assign child      = take_right ? right : left;
   assign child_slot = {slot_ff[hmtq_pkg::SLOT_W-2:0], take_right};

   // Decide: move a neighbor entry across the level boundary or settle the item.
   always_comb begin
      dn_tok_in_nx       = dn_tok_ff;
      dn_tok_in_nx.valid = 1'b0;
      dn_tok_in_nx.here  = 1'b0;
      up_tok_in_nx       = up_tok_ff;
      up_tok_in_nx.valid = 1'b0;
      up_tok_in_nx.here  = 1'b0;
      wr_up_in           = wr_up_ff;
      wr_up_in.valid     = 1'b0;
      wr_dn_in           = wr_dn_ff;
      wr_dn_in.valid     = 1'b0;
      done_in            = here_wr;
      own_wr             = 1'b0;
      own_slot           = '0;
      case (op_ff)
         OP_DOWN: begin
            wr_up_in.valid = 1'b1;
            wr_up_in.slot  = slot_ff;
            if (!left_ok || !(item_ff.expiry > child.expiry)) begin
               wr_up_in.item = item_ff;
               done_in       = 1'b1;
            end else begin
               wr_up_in.item = child;
               if (LAST) begin
                  own_wr   = 1'b1;
                  own_slot = child_slot;
                  done_in  = 1'b1;
               end else begin
                  dn_tok_in_nx.valid = 1'b1;
                  dn_tok_in_nx.slot  = child_slot;
                  dn_tok_in_nx.item  = item_ff;
               end
            end
         end
         OP_UP: begin
            wr_dn_in.valid = 1'b1;
            wr_dn_in.slot  = slot_ff;
            if (item_ff.expiry < parent.expiry) begin
               wr_dn_in.item = parent;
               if (LEVEL == 0) begin
                  own_wr   = 1'b1;
                  own_slot = '0;
                  done_in  = 1'b1;
               end else begin
                  up_tok_in_nx.valid = 1'b1;
                  up_tok_in_nx.slot  = slot_ff >> 1;
                  up_tok_in_nx.item  = item_ff;
               end
            end else begin
               wr_dn_in.item = item_ff;
               done_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mem_we   = 1'b0;
      mem_slot = own_slot;
      mem_data = item_ff;
      if (wr_in.valid) begin
         mem_we   = 1'b1;
         mem_slot = wr_in.slot;
         mem_data = wr_in.item;
      end else if (here_wr) begin
         mem_we   = 1'b1;
         mem_slot = up_tok_in.slot;
         mem_data = up_tok_in.item;
      end else if (own_wr) begin
         mem_we   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we && !mem_slot[0]) begin
         mem_even[mem_slot[ROW_BITS:1]] <= mem_data;
      end
      if (mem_we && mem_slot[0]) begin
         mem_odd[mem_slot[ROW_BITS:1]] <= mem_data;
      end
      rd_even_ff <= mem_even[rd_row];
      rd_odd_ff  <= mem_odd[rd_row];
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      item_ff   <= item_in;
      half_ff   <= half_in;
      dn_tok_ff <= dn_tok_in_nx;
      up_tok_ff <= up_tok_in_nx;
      wr_up_ff  <= wr_up_in;
      wr_dn_ff  <= wr_dn_in;
      if (reset) begin
         op_ff           <= OP_NONE;
         dn_tok_ff.valid <= 1'b0;
         up_tok_ff.valid <= 1'b0;
         wr_up_ff.valid  <= 1'b0;
         wr_dn_ff.valid  <= 1'b0;
         done_ff         <= 1'b0;
      end else begin
         op_ff   <= op_in;
         done_ff <= done_in;
      end
   end

   assign dn_tok_out = dn_tok_ff;
   assign up_tok_out = up_tok_ff;
   assign wr_up_out  = wr_up_ff;
   assign wr_dn_out  = wr_dn_ff;
   assign rd_entry   = parent;
   assign done       = done_ff;

endmodule

### hdl/min_heap_timer_queue.sv
// Top level of the min-heap timer queue: request sequencer and the chain of level cells.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+----------------------------------
//   req_bus   | in  | valid / ready      | req_type, timer_id, time_value
//   rsp_bus   | out | valid / ready      | fired_id, status, last
//
// One request at a time. A cancel or unused code goes straight to its response.
// An add sifts the new entry up through the levels it climbs; each pop of a tick
// moves the last entry into the root hole and sifts it down through the levels.
// Each level takes a registered read of the level memory in its cell,
// then the compare. Synchronous reset clears the count and all cancel marks;
// heap slots are not cleared. A stalled rsp_bus holds the sequencer.
module min_heap_timer_queue #(
   parameter int HEAP_DEPTH = 32,
   parameter int ID_COUNT   = 256
) (
   input  logic       clock,
   input  logic       reset,
   hmtq_req_if.sink   req_bus,
   hmtq_rsp_if.source rsp_bus
);

   localparam int NUM_LEVELS = $clog2(HEAP_DEPTH + 1);
   localparam int LVL_BITS   = $clog2(NUM_LEVELS);
   localparam int IDX_BITS   = $clog2(ID_COUNT);
   localparam int IDR_W      = hmtq_pkg::ID_W + 1;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_ROOT_RD  = 6'b000010,
      S_ROOT_CHK = 6'b000100,
      S_LAST_CHK = 6'b001000,
      S_WAIT     = 6'b010000,
      S_EMIT     = 6'b100000
   } seq_state_type;

   seq_state_type                  state_ff, state_in;
   logic [hmtq_pkg::REQ_W-1:0]     op_ff, op_in;
   logic [hmtq_pkg::TIME_W-1:0]    time_ff, time_in;
   logic [hmtq_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [ID_COUNT-1:0]            mark_ff, mark_in;
   logic [LVL_BITS-1:0]            lvl_ff, lvl_in;
   logic                           fire_ff, fire_in;
   logic [hmtq_pkg::ID_W-1:0]      res_id_ff, res_id_in;
   logic [hmtq_pkg::STAT_W-1:0]    res_stat_ff, res_stat_in;
   logic                           res_last_ff, res_last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hmtq_pkg::ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [hmtq_pkg::STAT_W-1:0]    rsp_stat_ff, rsp_stat_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Chain wiring, one element per heap level.
   hmtq_pkg::token_type dn_in  [NUM_LEVELS];
   hmtq_pkg::token_type up_in  [NUM_LEVELS];
   hmtq_pkg::token_type dn_out [NUM_LEVELS];
   hmtq_pkg::token_type up_out [NUM_LEVELS];
   hmtq_pkg::write_type wr_in  [NUM_LEVELS];
   hmtq_pkg::write_type wr_up  [NUM_LEVELS];
   hmtq_pkg::write_type wr_dn  [NUM_LEVELS];
   hmtq_pkg::fetch_type fetch  [NUM_LEVELS];
   hmtq_pkg::entry_type rd     [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] done_vec;

   hmtq_pkg::token_type ctrl_up, ctrl_dn;
   logic [LVL_BITS-1:0] ctrl_up_lvl;
   hmtq_pkg::fetch_type ctrl_fetch;
   logic [LVL_BITS-1:0] ctrl_fetch_lvl;

   logic [hmtq_pkg::CNT_W-1:0]  add_pos_p1, add_slot_full, pop_slot_full;
   logic [hmtq_pkg::LVLN_W-1:0] add_lvl, pop_lvl;
   logic                        out_free;
   logic                        req_in_range, top_marked;
   hmtq_pkg::entry_type         root;

   for (genvar lv = 0; lv < NUM_LEVELS; lv++) begin : g_level
      if (lv == 0) begin : g_dn_top
         assign dn_in[lv] = '0;
      end else if (lv == 1) begin : g_dn_first
         assign dn_in[lv] = ctrl_dn.valid ? ctrl_dn : dn_out[0];
      end else begin : g_dn_chain
         assign dn_in[lv] = dn_out[lv-1];
      end

      if (lv == NUM_LEVELS - 1) begin : g_up_last
         assign up_in[lv] = (ctrl_up.valid && ctrl_up_lvl == LVL_BITS'(lv)) ? ctrl_up : '0;
         assign wr_in[lv] = wr_dn[lv-1];
      end else if (lv == 0) begin : g_up_root
         assign up_in[lv] = (ctrl_up.valid && ctrl_up_lvl == LVL_BITS'(lv)) ? ctrl_up
                                                                            : up_out[lv+1];
         assign wr_in[lv] = wr_up[lv+1];
      end else begin : g_up_chain
         assign up_in[lv] = (ctrl_up.valid && ctrl_up_lvl == LVL_BITS'(lv)) ? ctrl_up
                                                                            : up_out[lv+1];
         assign wr_in[lv] = wr_dn[lv-1].valid ? wr_dn[lv-1] : wr_up[lv+1];
      end

      assign fetch[lv].valid = ctrl_fetch.valid && (ctrl_fetch_lvl == LVL_BITS'(lv));
      assign fetch[lv].slot  = ctrl_fetch.slot;

      hmtq_cell #(
         .LEVEL (lv),
         .LAST  (lv == NUM_LEVELS - 1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .dn_tok_in  (dn_in[lv]),
         .up_tok_in  (up_in[lv]),
         .wr_in      (wr_in[lv]),
         .fetch_in   (fetch[lv]),
         .dn_tok_out (dn_out[lv]),
         .up_tok_out (up_out[lv]),
         .wr_up_out  (wr_up[lv]),
         .wr_dn_out  (wr_dn[lv]),
         .rd_entry   (rd[lv]),
         .done       (done_vec[lv])
      );
   end

   // Position and slot arithmetic: a level-L position p has p + 1 in [2^L, 2^(L+1)).
   assign add_pos_p1    = count_ff + hmtq_pkg::CNT_W'(1);
   assign add_lvl       = hmtq_pkg::level_of(add_pos_p1);
   assign add_slot_full = add_pos_p1 ^ (hmtq_pkg::CNT_W'(1) << add_lvl);
   // Last entry after a pop sits at position count - 1.
   assign pop_lvl       = hmtq_pkg::level_of(count_ff);
   assign pop_slot_full = count_ff ^ (hmtq_pkg::CNT_W'(1) << pop_lvl);

   assign root         = rd[0];
   assign req_in_range = {1'b0, req_bus.timer_id} < IDR_W'(ID_COUNT);
   assign top_marked   = ({1'b0, root.ident} < IDR_W'(ID_COUNT))
                         && mark_ff[root.ident[IDX_BITS-1:0]];
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      time_in     = time_ff;
      count_in    = count_ff;
      mark_in     = mark_ff;
      lvl_in      = lvl_ff;
      fire_in     = fire_ff;
      res_id_in   = res_id_ff;
      res_stat_in = res_stat_ff;
      res_last_in = res_last_ff;

      ctrl_up        = '0;
      ctrl_up_lvl    = '0;
      ctrl_dn        = '0;
      ctrl_fetch     = '0;
      ctrl_fetch_lvl = '0;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in       = req_bus.req_type;
               time_in     = req_bus.time_value;
               res_id_in   = '0;
               res_stat_in = hmtq_pkg::ST_ACCEPTED;
               res_last_in = 1'b1;
               case (req_bus.req_type)
                  hmtq_pkg::REQ_ADD: begin
                     if (count_ff == hmtq_pkg::CNT_W'(HEAP_DEPTH)) begin
                        res_stat_in = hmtq_pkg::ST_FULL;
                        state_in    = S_EMIT;
                     end else begin
                        // Revive the id, open a hole at the end and sift it up.
                        if (req_in_range) begin
                           mark_in[req_bus.timer_id[IDX_BITS-1:0]] = 1'b0;
                        end
                        count_in           = add_pos_p1;
                        ctrl_up.valid      = 1'b1;
                        ctrl_up.slot       = add_slot_full[hmtq_pkg::SLOT_W-1:0];
                        ctrl_up.item       = {req_bus.time_value, req_bus.timer_id};
                        if (count_ff == '0) begin
                           ctrl_up.here = 1'b1;
                        end else begin
                           ctrl_up_lvl = LVL_BITS'(add_lvl) - LVL_BITS'(1);
                        end
                        state_in = S_WAIT;
                     end
                  end
                  hmtq_pkg::REQ_CANCEL: begin
                     if (req_in_range) begin
                        mark_in[req_bus.timer_id[IDX_BITS-1:0]] = 1'b1;
                     end
                     state_in = S_EMIT;
                  end
                  hmtq_pkg::REQ_TICK: begin
                     state_in = S_ROOT_RD;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_ROOT_RD: begin
            if (count_ff == '0) begin
               res_id_in   = '0;
               res_stat_in = hmtq_pkg::ST_DONE;
               res_last_in = 1'b1;
               state_in    = S_EMIT;
            end else begin
               ctrl_fetch.valid = 1'b1;
               state_in         = S_ROOT_CHK;
            end
         end

         S_ROOT_CHK: begin
            if (root.expiry <= time_ff) begin
               // Pop the root; a cancelled timer leaves silently.
               fire_in     = !top_marked;
               res_id_in   = root.ident;
               res_stat_in = hmtq_pkg::ST_FIRED;
               res_last_in = 1'b0;
               count_in    = count_ff - hmtq_pkg::CNT_W'(1);
               if (count_ff == hmtq_pkg::CNT_W'(1)) begin
                  state_in = top_marked ? S_ROOT_RD : S_EMIT;
               end else begin
                  ctrl_fetch.valid = 1'b1;
                  ctrl_fetch.slot  = pop_slot_full[hmtq_pkg::SLOT_W-1:0];
                  ctrl_fetch_lvl   = LVL_BITS'(pop_lvl);
                  lvl_in           = LVL_BITS'(pop_lvl);
                  state_in         = S_LAST_CHK;
               end
            end else begin
               res_id_in   = '0;
               res_stat_in = hmtq_pkg::ST_DONE;
               res_last_in = 1'b1;
               state_in    = S_EMIT;
            end
         end

         S_LAST_CHK: begin
            // Move the last entry into the root hole and sift it down.
            ctrl_dn.valid = 1'b1;
            ctrl_dn.item  = rd[lvl_ff];
            state_in      = S_WAIT;
         end

         S_WAIT: begin
            if (|done_vec) begin
               if (op_ff == hmtq_pkg::REQ_ADD) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = fire_ff ? S_EMIT : S_ROOT_RD;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_last_in  = res_last_ff;
               state_in     = res_last_ff ? S_IDLE : S_ROOT_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      time_ff     <= time_in;
      lvl_ff      <= lvl_in;
      fire_ff     <= fire_in;
      res_id_ff   <= res_id_in;
      res_stat_ff <= res_stat_in;
      res_last_ff <= res_last_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_bus.ready    = (state_ff == S_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.fired_id = rsp_id_ff;
   assign rsp_bus.status   = rsp_stat_ff;
   assign rsp_bus.last     = rsp_last_ff;

endmodule
